/* hdl/bsbe_pkg.sv */
package bsbe_pkg;

   localparam int STACK_BYTES = 256;
   localparam int SP_W = $clog2(STACK_BYTES + 1);
   localparam int ADDR_W = $clog2(STACK_BYTES);
   localparam int DEPTH_W = 9;

   localparam logic [3:0] FN_CONST = 4'd0;
   localparam logic [3:0] FN_ADD = 4'd1;
   localparam logic [3:0] FN_SUB = 4'd2;
   localparam logic [3:0] FN_MUL = 4'd3;
   localparam logic [3:0] FN_DIV = 4'd4;
   localparam logic [3:0] FN_NEG = 4'd5;
   localparam logic [3:0] FN_TRUE = 4'd6;
   localparam logic [3:0] FN_FALSE = 4'd7;
   localparam logic [3:0] FN_NOT = 4'd8;
   localparam logic [3:0] FN_EQ = 4'd9;
   localparam logic [3:0] FN_GT = 4'd10;
   localparam logic [3:0] FN_LT = 4'd11;
   localparam logic [3:0] FN_RET = 4'd12;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER = 2'd2;
   localparam logic [1:0] ST_DIV0 = 2'd3;

   // datapath write source
   localparam logic [1:0] WS_IMM = 2'd0;
   localparam logic [1:0] WS_RES = 2'd1;
   localparam logic [1:0] WS_BOOL = 2'd2;

   typedef struct packed {
      logic [3:0] func;
      logic [31:0] immediate;
      logic compare_type;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic returned;
      logic return_value;
      logic [DEPTH_W-1:0] stack_depth;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic ld_a;          // shift read byte into operand a
      logic ld_b;          // shift read byte into operand b
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [1:0] wr_src;
      logic [1:0] wr_byte;
      logic wr_bool;
      logic alu_go;        // latch arithmetic result
      logic div_start;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic a_eq_b;
      logic a_gt_b;
      logic a_lt_b;
      logic b_zero;
      logic rd_nonzero;
      logic b_nonzero;
   } sts_type;

endpackage

/* hdl/bsbe_if.sv */
interface bsbe_req_if import bsbe_pkg::*; ();
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bsbe_rsp_if import bsbe_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/bsbe_div.sv */
module bsbe_div import bsbe_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [31:0] a,
   input logic [31:0] b,
   output logic done,
   output logic [31:0] quot
);
   logic [31:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] rem_sh;

   always_comb begin
      rem_in = rem_ff;
      q_in = q_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh = {rem_ff[30:0], q_ff[31]};
      trial = {1'b0, rem_sh} - {1'b0, d_ff};
      if (start) begin
         rem_in = '0;
         q_in = a[31] ? 32'd0 - a : a;
         d_in = b[31] ? 32'd0 - b : b;
         neg_in = a[31] ^ b[31];
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step: one quotient bit per cycle
         if (!trial[32]) begin
            rem_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff <= q_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? 32'd0 - q_ff : q_ff;
endmodule

/* hdl/bsbe_datapath.sv */
module bsbe_datapath import bsbe_pkg::*; (
   input logic clock,
   input logic reset,
   input cmd_type cmd,
   input logic [3:0] func,
   input logic [31:0] immediate,
   output sts_type sts
);
   logic [7:0] mem [STACK_BYTES];
   logic [7:0] rd_ff;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] res_ff, res_in;
   logic ld_a_ff, ld_b_ff;
   logic [31:0] wr_word;
   logic [7:0] wr_data;
   logic [31:0] quot;
   logic div_done;

   bsbe_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .a(a_ff), .b(b_ff), .done(div_done), .quot(quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rd_ff <= mem[cmd.rd_addr];
      if (cmd.wr_en) mem[cmd.wr_addr] <= wr_data;
   end

   // read data lands the cycle after the read; ld_a/ld_b are registered to match
   always_comb begin
      a_in = ld_a_ff ? {rd_ff, a_ff[31:8]} : a_ff;
      b_in = ld_b_ff ? {rd_ff, b_ff[31:8]} : b_ff;
      res_in = res_ff;
      if (cmd.alu_go) begin
         case (func)
            FN_ADD: res_in = a_ff + b_ff;
            FN_SUB: res_in = a_ff - b_ff;
            FN_MUL: res_in = a_ff * b_ff;
            FN_NEG: res_in = 32'd0 - b_ff;
            default: res_in = res_ff;
         endcase
      end
      if (div_done) res_in = quot;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      res_ff <= res_in;
      if (reset) begin
         ld_a_ff <= 1'b0;
         ld_b_ff <= 1'b0;
      end else begin
         ld_a_ff <= cmd.ld_a;
         ld_b_ff <= cmd.ld_b;
      end
   end

   always_comb begin
      case (cmd.wr_src)
         WS_IMM: wr_word = immediate;
         WS_RES: wr_word = res_ff;
         default: wr_word = 32'd0;
      endcase
      case (cmd.wr_byte)
         2'd0: wr_data = wr_word[7:0];
         2'd1: wr_data = wr_word[15:8];
         2'd2: wr_data = wr_word[23:16];
         default: wr_data = wr_word[31:24];
      endcase
      if (cmd.wr_src == WS_BOOL) wr_data = {7'd0, cmd.wr_bool};
   end

   assign sts.div_done = div_done;
   assign sts.a_eq_b = a_ff == b_ff;
   assign sts.a_gt_b = $signed(a_ff) > $signed(b_ff);
   assign sts.a_lt_b = $signed(a_ff) < $signed(b_ff);
   assign sts.b_zero = b_ff == 32'd0;
   assign sts.rd_nonzero = rd_ff != 8'd0;
   assign sts.b_nonzero = b_ff[31:24] != 8'd0;
endmodule

/* hdl/bsbe_ctrl.sv */
module bsbe_ctrl import bsbe_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_fire,
   input req_type req_in,
   input sts_type sts,
   input logic rsp_free,
   output logic busy,
   output logic rsp_load,
   output rsp_type rsp_data,
   output cmd_type cmd,
   output logic [3:0] func
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [SP_W-1:0] base_ff, base_in;   // lowest byte of operands, also write base
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] nrd_ff, nrd_in;          // bytes to read
   logic [2:0] nwr_ff, nwr_in;          // bytes to write
   logic [3:0] func_ff, func_in;
   logic ctype_ff, ctype_in;
   logic [1:0] stat_ff, stat_in;
   logic ret_ff, ret_in;
   logic rval_ff, rval_in;
   logic wbool_ff, wbool_in;
   logic [1:0] wsrc_ff, wsrc_in;
   logic [SP_W-1:0] rd_pos;
   logic [SP_W-1:0] wr_pos;
   logic bool_a_ff, bool_a_in;

   assign func = func_ff;

   always_comb begin
      state_in = state_ff;
      sp_in = sp_ff;
      base_in = base_ff;
      cnt_in = cnt_ff;
      nrd_in = nrd_ff;
      nwr_in = nwr_ff;
      func_in = func_ff;
      ctype_in = ctype_ff;
      stat_in = stat_ff;
      ret_in = ret_ff;
      rval_in = rval_ff;
      wbool_in = wbool_ff;
      wsrc_in = wsrc_ff;
      bool_a_in = bool_a_ff;
      cmd = '0;
      rsp_load = 1'b0;
      rd_pos = base_ff + SP_W'(cnt_ff);
      wr_pos = base_ff + SP_W'(cnt_ff);
      cmd.rd_addr = rd_pos[ADDR_W-1:0];
      cmd.wr_addr = wr_pos[ADDR_W-1:0];
      cmd.wr_src = wsrc_ff;
      cmd.wr_byte = cnt_ff[1:0];
      cmd.wr_bool = wbool_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in = req_in.func;
               ctype_in = req_in.compare_type;
               stat_in = ST_OK;
               ret_in = 1'b0;
               rval_in = 1'b0;
               cnt_in = '0;
               nrd_in = '0;
               nwr_in = '0;
               base_in = sp_ff;
               wsrc_in = WS_BOOL;
               state_in = S_DONE;
               case (req_in.func)
                  FN_CONST: begin
                     if (32'(sp_ff) + 32'd4 > 32'(STACK_BYTES)) stat_in = ST_OVER;
                     else begin
                        nwr_in = 3'd4; wsrc_in = WS_IMM;
                        sp_in = sp_ff + SP_W'(4); state_in = S_WRITE;
                     end
                  end
                  FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_GT, FN_LT: begin
                     if (sp_ff < SP_W'(8)) stat_in = ST_UNDER;
                     else begin
                        base_in = sp_ff - SP_W'(8); nrd_in = 4'd8; state_in = S_READ;
                     end
                  end
                  FN_NEG: begin
                     if (sp_ff < SP_W'(4)) stat_in = ST_UNDER;
                     else begin
                        base_in = sp_ff - SP_W'(4); nrd_in = 4'd4; state_in = S_READ;
                     end
                  end
                  FN_TRUE, FN_FALSE: begin
                     if (32'(sp_ff) + 32'd1 > 32'(STACK_BYTES)) stat_in = ST_OVER;
                     else begin
                        nwr_in = 3'd1; wbool_in = req_in.func == FN_TRUE;
                        sp_in = sp_ff + SP_W'(1); state_in = S_WRITE;
                     end
                  end
                  FN_NOT, FN_RET: begin
                     if (sp_ff < SP_W'(1)) stat_in = ST_UNDER;
                     else begin
                        base_in = sp_ff - SP_W'(1); nrd_in = 4'd1; state_in = S_READ;
                     end
                  end
                  FN_EQ: begin
                     if (req_in.compare_type) begin
                        if (sp_ff < SP_W'(2)) stat_in = ST_UNDER;
                        else begin
                           base_in = sp_ff - SP_W'(2); nrd_in = 4'd2; state_in = S_READ;
                        end
                     end else if (sp_ff < SP_W'(8)) stat_in = ST_UNDER;
                     else begin
                        base_in = sp_ff - SP_W'(8); nrd_in = 4'd8; state_in = S_READ;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_READ: begin
            // bytes land in b; for 8-byte reads the first four go into a
            if (cnt_ff < nrd_ff) begin
               cmd.rd_en = 1'b1;
               cmd.ld_a = nrd_ff == 4'd8 && cnt_ff < 4'd4;
               cmd.ld_b = !cmd.ld_a;
               cnt_in = cnt_ff + 4'd1;
            end else begin
               cnt_in = '0;
               state_in = S_EXEC;
            end
            // first byte of a bool eq is y; keep its truth once it lands
            if (nrd_ff == 4'd2 && cnt_ff == 4'd1) bool_a_in = sts.rd_nonzero;
         end
         S_EXEC: begin
            // operand loads have settled here
            state_in = S_WRITE;
            wsrc_in = WS_BOOL;
            cnt_in = '0;
            case (func_ff)
               FN_ADD, FN_SUB, FN_MUL: begin
                  cmd.alu_go = 1'b1; wsrc_in = WS_RES; nwr_in = 3'd4;
                  sp_in = base_ff + SP_W'(4);
               end
               FN_NEG: begin
                  cmd.alu_go = 1'b1; wsrc_in = WS_RES; nwr_in = 3'd4;
               end
               FN_DIV: begin
                  if (sts.b_zero) begin
                     stat_in = ST_DIV0; state_in = S_DONE;
                  end else begin
                     cmd.div_start = 1'b1; wsrc_in = WS_RES; nwr_in = 3'd4;
                     sp_in = base_ff + SP_W'(4); state_in = S_DIV;
                  end
               end
               FN_GT, FN_LT: begin
                  nwr_in = 3'd1; sp_in = base_ff + SP_W'(1);
                  wbool_in = func_ff == FN_GT ? sts.a_gt_b : sts.a_lt_b;
               end
               FN_NOT: begin
                  nwr_in = 3'd1; wbool_in = !sts.b_nonzero;
               end
               FN_EQ: begin
                  nwr_in = 3'd1; sp_in = base_ff + SP_W'(1);
                  if (ctype_ff) wbool_in = bool_a_ff == sts.b_nonzero;
                  else wbool_in = sts.a_eq_b;
               end
               FN_RET: begin
                  ret_in = 1'b1; rval_in = sts.b_nonzero;
                  sp_in = base_ff; state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr_en = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(nwr_ff) - 4'd1) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_data.status = stat_ff;
      rsp_data.returned = ret_ff;
      rsp_data.return_value = rval_ff;
      rsp_data.stack_depth = DEPTH_W'(sp_ff);
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      nrd_ff <= nrd_in;
      nwr_ff <= nwr_in;
      func_ff <= func_in;
      ctype_ff <= ctype_in;
      stat_ff <= stat_in;
      ret_ff <= ret_in;
      rval_ff <= rval_in;
      wbool_ff <= wbool_in;
      wsrc_ff <= wsrc_in;
      bool_a_ff <= bool_a_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
      end
   end

   assign busy = state_ff != S_IDLE;
endmodule

/* hdl/byte_stack_bytecode_executor.sv */
// channel   dir  handshake        payload
// req_      in   valid/ready      func, immediate, compare_type
// rsp_      out  valid/ready      status, returned, return_value, stack_depth
// One instruction at a time. Stack bytes move through a byte memory with separate read
// and write addresses, one byte per cycle. After accept the core reads any operand bytes
// and executes on them, writes any result bytes and loads the result register; a failed
// check goes straight to the result load. Divide runs in the restoring divider before the write.
// Synchronous reset empties the stack; stack contents are not cleared.
// The result register frees the core: the next instruction starts while a result waits,
// and the core holds only when it has a new result and the register is still full.
module byte_stack_bytecode_executor import bsbe_pkg::*; (
   input logic clock,
   input logic reset,
   bsbe_req_if.sink req,
   bsbe_rsp_if.source rsp
);
   cmd_type cmd;
   sts_type sts;
   logic busy;
   logic rsp_load;
   rsp_type rsp_data;
   logic [3:0] func;
   logic req_fire;
   logic [31:0] imm_hold_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   assign req.ready = !busy;
   assign req_fire = req.valid && req.ready;

   // hold the immediate for the byte writes
   always_ff @(posedge clock) begin
      if (req_fire) imm_hold_ff <= req.payload.immediate;
   end

   bsbe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_in(req.payload),
      .sts(sts), .rsp_free(!rsp_valid_ff || rsp.ready), .busy(busy),
      .rsp_load(rsp_load), .rsp_data(rsp_data), .cmd(cmd), .func(func)
   );

   bsbe_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .func(func),
      .immediate(imm_hold_ff), .sts(sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_data;
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_fire) else $error("accept while busy");
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp.ready)) else $error("result overwritten");
   a_ret_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.returned) |-> rsp.payload.status == ST_OK)
      else $error("return with error status");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.stack_depth <= DEPTH_W'(STACK_BYTES))
      else $error("depth beyond stack");
endmodule
